// ===== rtl/bnps_pkg.sv =====
// ----------------------------------------------------------------------------
// bnps_pkg: shared types and constants
// Widths, operation codes, item structs and the memory request bundle of the
// bitmap next/previous bit search core.
// ----------------------------------------------------------------------------
package bnps_pkg;

  localparam int MAX_BITS   = 4096;
  localparam int BYTE_BITS  = 8;
  localparam int BYTE_COUNT = (MAX_BITS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int ADDR_W     = $clog2(BYTE_COUNT);
  localparam int BIT_W      = $clog2(BYTE_BITS);
  localparam int IDX_W      = ADDR_W + BIT_W;
  localparam int POS_W      = 13;
  localparam int COUNT_W    = 13;

  localparam logic [BYTE_BITS-1:0] BYTE_ONES = 8'hFF;
  localparam logic [BIT_W-1:0]     BIT_TOP   = 3'd7;
  localparam logic [POS_W-1:0]     POS_ONE   = 13'd1;

  localparam logic DIR_FORWARD  = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE_BYTE    = 3'd0,
    OP_GO_TO         = 3'd1,
    OP_STEP          = 3'd2,
    OP_SEEK          = 3'd3,
    OP_SEEK_FROM_END = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] target_position;
    logic        direction;
    logic        want_value;
    logic [8:0]  byte_index;
    logic [7:0]  byte_data;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [12:0] position;
  } out_item_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [BYTE_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

// ===== rtl/bitmap_next_prev_bit_search_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_next_prev_bit_search_core: bitmap position tracker with bit search
// Holds a bitmap of bytes and a current position; loads bytes, jumps, steps
// and seeks the nearest set or clear bit in either direction.
//
//   channel | direction | handshake        | payload
//   cfg     | in        | cfg_valid/ready  | cfg_data, bit_count
//   in      | in        | in_valid/stall   | in_data, in_item_t
//   out     | out       | out_valid/stall  | out_data, out_item_t
//
// Write_byte, go_to, step and a seek with nothing to scan need no bitmap scan;
// the result is registered at the transfer edge. A seek scans 1 to BYTE_COUNT
// bytes, one at a time through the single bitmap read port.
// Synchronous reset sets position 1 and bit_count 4096; the bitmap itself is
// not cleared and must be written before it is searched.
// A stalled result waits in a skid slot. in_stall is high while a seek scans
// and when that slot is full as well.
// ----------------------------------------------------------------------------
module bitmap_next_prev_bit_search_core
  import bnps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  logic [COUNT_W-1:0]   bit_count;
  logic [COUNT_W-1:0]   count;
  logic                 res_space;
  logic                 res_push;
  out_item_t            res_data;
  mem_req_t             mem_req;
  logic [BYTE_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= COUNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      bit_count <= cfg_data;
    end
  end

  // The searchable range is clamped to the bitmap size.
  assign count = (bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count;

  bnps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .count     (count),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_space (res_space),
    .res_push  (res_push),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  bnps_bitmap_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bnps_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .space     (res_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/bnps_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bnps_bitmap_ram: bitmap byte store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bnps_bitmap_ram
  import bnps_pkg::*;
(
  input  logic                 clk,
  input  mem_req_t             req,
  output logic [BYTE_BITS-1:0] rd_data
);

  logic [BYTE_BITS-1:0] mem [BYTE_COUNT];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/bnps_ctrl.sv =====
// ----------------------------------------------------------------------------
// bnps_ctrl: operation sequencer and byte scanner
// Holds the current position, executes the simple operations in the cycle of
// the transfer and walks the bitmap one byte per cycle for the seeks.
// ----------------------------------------------------------------------------
module bnps_ctrl
  import bnps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [COUNT_W-1:0]   count,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 res_space,
  output logic                 res_push,
  output out_item_t            res_data,
  output mem_req_t             mem_req,
  input  logic [BYTE_BITS-1:0] rd_data
);

  state_t state, state_next;

  logic [POS_W-1:0]  position, position_next;
  logic              dir, dir_next;
  logic              want, want_next;
  logic [ADDR_W-1:0] cur_byte, cur_byte_next;
  logic [BIT_W-1:0]  edge_bit, edge_bit_next;
  logic              first, first_next;
  logic [ADDR_W-1:0] last_byte, last_byte_next;
  logic [BIT_W-1:0]  last_bit, last_bit_next;

  logic                 accept;
  logic                 count_nz;
  logic [POS_W-1:0]     count_m1;
  logic [POS_W-1:0]     pos_m1;
  logic [POS_W-1:0]     back_start;
  logic [POS_W-1:0]     back_start_m1;
  logic                 seek_go;
  logic [IDX_W-1:0]     start_idx;
  logic [BYTE_BITS-1:0] lo_mask, hi_mask, match;
  logic [BIT_W-1:0]     hit_bit;
  logic                 hit;
  logic                 at_end;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || !res_space;
  assign count_nz = (count != '0);
  assign count_m1 = count - POS_ONE;
  assign pos_m1   = position - POS_ONE;

  // Backward seek starts at min(position - 1, count).
  assign back_start    = (pos_m1 > count) ? count : pos_m1;
  assign back_start_m1 = back_start - POS_ONE;

  // Whether a seek has anything to scan, and its zero-based first bit.
  always_comb begin
    seek_go   = 1'b0;
    start_idx = '0;
    if (in_data.op == OP_SEEK) begin
      if (in_data.direction == DIR_FORWARD) begin
        seek_go   = count_nz && (position < count);
        start_idx = position[IDX_W-1:0];
      end else begin
        seek_go   = count_nz && (position > POS_ONE);
        start_idx = back_start_m1[IDX_W-1:0];
      end
    end else if (in_data.op == OP_SEEK_FROM_END) begin
      seek_go   = count_nz;
      start_idx = (in_data.direction == DIR_FORWARD) ? '0 : count_m1[IDX_W-1:0];
    end
  end

  // Byte match: bits outside the search window are masked off.
  always_comb begin
    lo_mask = BYTE_ONES;
    hi_mask = BYTE_ONES;
    if (dir == DIR_FORWARD) begin
      if (first) begin
        lo_mask = BYTE_ONES << edge_bit;
      end
      if (cur_byte == last_byte) begin
        hi_mask = BYTE_ONES >> (BIT_TOP - last_bit);
      end
    end else if (first) begin
      hi_mask = BYTE_ONES >> (BIT_TOP - edge_bit);
    end
    match = (want ? rd_data : ~rd_data) & lo_mask & hi_mask;
  end

  // Forward takes the lowest matching bit, backward the highest.
  always_comb begin
    hit_bit = '0;
    if (dir == DIR_FORWARD) begin
      for (int k = BYTE_BITS - 1; k >= 0; k--) begin
        if (match[k]) begin
          hit_bit = BIT_W'(k);
        end
      end
    end else begin
      for (int k = 0; k < BYTE_BITS; k++) begin
        if (match[k]) begin
          hit_bit = BIT_W'(k);
        end
      end
    end
  end

  assign hit    = (match != '0);
  assign at_end = (dir == DIR_FORWARD) ? (cur_byte == last_byte) : (cur_byte == '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && seek_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath register updates.
  always_comb begin
    position_next  = position;
    dir_next       = dir;
    want_next      = want;
    cur_byte_next  = cur_byte;
    edge_bit_next  = edge_bit;
    first_next     = first;
    last_byte_next = last_byte;
    last_bit_next  = last_bit;
    res_push       = 1'b0;
    res_data.found = 1'b0;
    mem_req        = '0;
    mem_req.wr_addr = in_data.byte_index;
    mem_req.wr_data = in_data.byte_data;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_push = 1'b1;
          unique case (in_data.op) inside
            OP_WRITE_BYTE: begin
              // Every 9-bit byte index lies inside the bitmap.
              mem_req.wr_en  = 1'b1;
              res_data.found = 1'b1;
            end
            OP_GO_TO: begin
              if (in_data.target_position != '0 && in_data.target_position <= count) begin
                position_next  = in_data.target_position;
                res_data.found = 1'b1;
              end
            end
            OP_STEP: begin
              if (count_nz) begin
                if (in_data.direction == DIR_FORWARD) begin
                  if (position < count) begin
                    position_next  = position + POS_ONE;
                    res_data.found = 1'b1;
                  end
                end else if (position > POS_ONE) begin
                  position_next  = pos_m1;
                  res_data.found = 1'b1;
                end
              end
            end
            OP_SEEK, OP_SEEK_FROM_END: begin
              if (seek_go) begin
                res_push        = 1'b0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = start_idx[IDX_W-1:BIT_W];
                dir_next        = in_data.direction;
                want_next       = in_data.want_value;
                cur_byte_next   = start_idx[IDX_W-1:BIT_W];
                edge_bit_next   = start_idx[BIT_W-1:0];
                first_next      = 1'b1;
                last_byte_next  = count_m1[IDX_W-1:BIT_W];
                last_bit_next   = count_m1[BIT_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          position_next  = POS_W'({cur_byte, hit_bit}) + POS_ONE;
          res_push       = 1'b1;
          res_data.found = 1'b1;
        end else if (at_end) begin
          res_push = 1'b1;
        end else begin
          cur_byte_next   = (dir == DIR_FORWARD) ? cur_byte + 1'b1 : cur_byte - 1'b1;
          first_next      = 1'b0;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cur_byte_next;
        end
      end
      default: ;
    endcase
    res_data.position = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      position <= POS_ONE;
    end else begin
      state    <= state_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    dir       <= dir_next;
    want      <= want_next;
    cur_byte  <= cur_byte_next;
    edge_bit  <= edge_bit_next;
    first     <= first_next;
    last_byte <= last_byte_next;
    last_bit  <= last_bit_next;
  end

`ifndef SYNTHESIS
  // The bitmap is never written while a scan reads it.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem_req.wr_en)
    else $error("bitmap write during scan");

  // A scan either reads the next byte or delivers its result.
  a_scan_progress: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (mem_req.rd_en != res_push))
    else $error("scan neither advanced nor finished");

  // The position stays within 1..MAX_BITS.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (position != '0) && (position <= POS_W'(MAX_BITS)))
    else $error("position out of range");
`endif

endmodule

// ===== rtl/bnps_out_stage.sv =====
// ----------------------------------------------------------------------------
// bnps_out_stage: result register with skid slot
// Lets the sequencer finish an operation while the previous result is still
// stalled at the output.
// ----------------------------------------------------------------------------
module bnps_out_stage
  import bnps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  output logic      space,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      skid_valid;
  out_item_t skid_data;
  logic      pop;

  assign pop   = out_valid && !out_stall;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  // The skid slot only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds data while output is empty");

  // A full skid slot never receives another result.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full output stage");
`endif

endmodule

// ===== tb/bitmap_next_prev_bit_search_core_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_next_prev_bit_search_core_test: self-checking testbench
// Loads bitmap bytes, jumps, steps and seeks through the input channel while
// a scoreboard keeps its own bitmap, position and bit_count to predict every
// result. Results are checked in order across several bit_count settings and
// sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module bitmap_next_prev_bit_search_core_test;
  import bnps_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 48;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  class bit_search_checker;
    logic [BYTE_BITS-1:0] bitmap [BYTE_COUNT];
    bit written [BYTE_COUNT];
    int cur_pos = 1;
    int bit_count = MAX_BITS;
    out_item_t expected_moves [$];
    int errors = 0;

    function int eff_count();
      return (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      bit_count = int'(value);
    endfunction

    function logic [BYTE_BITS-1:0] rand_byte();
      case ($urandom_range(2))
        0: return '0;
        1: return BYTE_ONES;
        default: return BYTE_BITS'($urandom);
      endcase
    endfunction

    // Walks from start toward the end named by dir and returns the first
    // position holding want, or 0. A byte never loaded stops the walk.
    function int find_bit(int start, logic dir, logic want, output int unloaded);
      int count;
      int p;
      int b;
      int delta;
      count = eff_count();
      p = start;
      unloaded = -1;
      delta = (dir == DIR_FORWARD) ? 1 : -1;
      if (dir == DIR_FORWARD && p < 1) p = 1;
      if (dir == DIR_BACKWARD && p > count) p = count;
      while (p >= 1 && p <= count) begin
        b = (p - 1) / BYTE_BITS;
        if (!written[ADDR_W'(b)]) begin
          unloaded = b;
          return 0;
        end
        if (bitmap[ADDR_W'(b)][BIT_W'((p - 1) % BYTE_BITS)] == want) return p;
        p += delta;
      end
      return 0;
    endfunction

    function int seek_hit(in_item_t it, output int unloaded);
      int count;
      count = eff_count();
      unloaded = -1;
      if (count == 0) return 0;
      if (it.op == OP_SEEK_FROM_END) begin
        if (it.direction == DIR_FORWARD)
          return find_bit(1, it.direction, it.want_value, unloaded);
        return find_bit(count, it.direction, it.want_value, unloaded);
      end
      if (it.direction == DIR_FORWARD) begin
        if (cur_pos < count) return find_bit(cur_pos + 1, it.direction, it.want_value, unloaded);
        return 0;
      end
      if (cur_pos > 1) return find_bit(cur_pos - 1, it.direction, it.want_value, unloaded);
      return 0;
    endfunction

    // A seek that would run into a byte never loaded becomes a load of that
    // byte instead, so the bitmap fills along the paths that seeks take.
    function in_item_t safe_op(in_item_t it);
      int unloaded;
      if (it.op == OP_SEEK || it.op == OP_SEEK_FROM_END) begin
        void'(seek_hit(it, unloaded));
        if (unloaded >= 0) begin
          it.op = OP_WRITE_BYTE;
          it.byte_index = ADDR_W'(unloaded);
          it.byte_data = rand_byte();
        end
      end
      return it;
    endfunction

    function out_item_t predict_result(in_item_t it);
      out_item_t r;
      int count;
      int hit;
      int unloaded;
      count = eff_count();
      r.found = 1'b0;
      case (it.op)
        OP_WRITE_BYTE: begin
          if (it.byte_index < BYTE_COUNT) begin
            bitmap[it.byte_index] = it.byte_data;
            written[it.byte_index] = 1'b1;
            r.found = 1'b1;
          end
        end
        OP_GO_TO: begin
          if (it.target_position >= 1 && it.target_position <= count) begin
            cur_pos = int'(it.target_position);
            r.found = 1'b1;
          end
        end
        OP_STEP: begin
          if (count > 0) begin
            if (it.direction == DIR_FORWARD) begin
              if (cur_pos < count) begin
                cur_pos++;
                r.found = 1'b1;
              end
            end else if (cur_pos > 1) begin
              cur_pos--;
              r.found = 1'b1;
            end
          end
        end
        OP_SEEK, OP_SEEK_FROM_END: begin
          hit = seek_hit(it, unloaded);
          if (hit != 0) begin
            cur_pos = hit;
            r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.position = POS_W'(cur_pos);
      return r;
    endfunction

    function void record_op(in_item_t it);
      expected_moves.push_back(predict_result(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_moves.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found=%0b position=%0d", got.found, got.position);
        return;
      end
      want = expected_moves.pop_front();
      if (got.found !== want.found || got.position !== want.position) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                   want.found, want.position, got.found, got.position);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  bit_search_checker sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  bitmap_next_prev_bit_search_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every transfer is observed here, at the edge where it happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_count(cfg_data);
      if (in_valid && !in_stall) sb.record_op(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(negedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_item_t op_item(logic [2:0] op, int target, logic dir, logic want,
                                       int idx, int data);
    in_item_t it;
    it.op = op;
    it.target_position = POS_W'(target);
    it.direction = dir;
    it.want_value = want;
    it.byte_index = ADDR_W'(idx);
    it.byte_data = BYTE_BITS'(data);
    return it;
  endfunction

  function automatic in_item_t random_op();
    in_item_t it;
    int count;
    int sel;
    count = sb.eff_count();
    sel = $urandom_range(99);
    it.op = 3'($urandom);
    it.target_position = POS_W'($urandom);
    it.direction = 1'($urandom);
    it.want_value = 1'($urandom);
    it.byte_index = ADDR_W'($urandom);
    it.byte_data = BYTE_BITS'($urandom);
    if (sel < 18) begin
      it.op = OP_WRITE_BYTE;
      if ($urandom_range(9) < 7)
        it.byte_index = ADDR_W'($urandom_range(count == 0 ? 0 : (count - 1) / BYTE_BITS));
      it.byte_data = sb.rand_byte();
    end else if (sel < 33) begin
      it.op = OP_GO_TO;
      case ($urandom_range(4))
        0, 1, 2: it.target_position = POS_W'($urandom_range(count + 2));
        3: ;
        default: it.target_position = $urandom_range(1) ? POS_W'(count) : POS_W'(count + 1);
      endcase
    end else if (sel < 55) begin
      it.op = OP_STEP;
    end else if (sel < 85) begin
      it.op = OP_SEEK;
    end else if (sel < 95) begin
      it.op = OP_SEEK_FROM_END;
    end else begin
      it.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= sb.safe_op(it);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_moves.size() != 0) @(negedge clk);
  endtask

  task automatic write_bit_count(int value);
    cfg_valid <= 1'b1;
    cfg_data <= COUNT_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase_counts [9];
    int mode;
    phase_counts = '{37, 8191, 1, 8, 200, 4096, 0, 4095, 13};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed checks at the reset bit_count of 4096.
    send(op_item(OP_WRITE_BYTE, 0, DIR_FORWARD, 1'b0, 0, 'h01));
    send(op_item(OP_WRITE_BYTE, 0, DIR_FORWARD, 1'b0, BYTE_COUNT - 1, 'h80));
    send(op_item(OP_SEEK_FROM_END, 0, DIR_FORWARD, 1'b1, 0, 0));
    send(op_item(OP_SEEK_FROM_END, 0, DIR_BACKWARD, 1'b1, 0, 0));
    send(op_item(OP_STEP, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_FORWARD, 1'b1, 0, 0));
    send(op_item(OP_GO_TO, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_GO_TO, 8191, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_GO_TO, 1, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_STEP, 0, DIR_BACKWARD, 1'b0, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_BACKWARD, 1'b1, 0, 0));
    send(op_item(OP_WRITE_BYTE, 0, DIR_FORWARD, 1'b0, 1, int'(BYTE_ONES)));
    send(op_item(OP_SEEK, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_STEP, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_GO_TO, 8, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_FORWARD, 1'b1, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_BACKWARD, 1'b1, 0, 0));
    send(op_item(OP_UNUSED_LO, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_UNUSED_HI, 8191, DIR_BACKWARD, 1'b1, BYTE_COUNT - 1, int'(BYTE_ONES)));
    send(op_item(OP_GO_TO, MAX_BITS, DIR_FORWARD, 1'b0, 0, 0));

    // Lowering bit_count leaves the position beyond the valid range.
    wait_drained();
    write_bit_count(20);
    send(op_item(OP_WRITE_BYTE, 0, DIR_FORWARD, 1'b0, 2, 'h00));
    send(op_item(OP_STEP, 0, DIR_BACKWARD, 1'b0, 0, 0));
    send(op_item(OP_STEP, 0, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_BACKWARD, 1'b0, 0, 0));

    // An empty bitmap makes every move and search fail.
    wait_drained();
    write_bit_count(0);
    send(op_item(OP_GO_TO, 1, DIR_FORWARD, 1'b0, 0, 0));
    send(op_item(OP_SEEK, 0, DIR_FORWARD, 1'b1, 0, 0));
    send(op_item(OP_SEEK_FROM_END, 0, DIR_BACKWARD, 1'b0, 0, 0));

    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      write_bit_count(phase_counts[ph]);
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 84 : (mode == 3) ? 22 : 0;
      recv_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 22 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && ph % 3 == 0) wait_drained();
        send(random_op());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_moves.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
